// ----- hw/rtl/dtss_pkg.sv -----
// ----------------------------------------------------------------------------
// dtss_pkg
// Shared types and constants of the decimal digit trie seen-set.
// ----------------------------------------------------------------------------
package dtss_pkg;

    localparam int MAX_NODES_DEF = 4096;
    localparam int FANOUT        = 10;
    localparam int DIGIT_W       = 4;
    localparam int STATUS_W      = 2;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(FANOUT - 1);

    typedef enum logic [STATUS_W-1:0] {
        ST_NEW     = 2'd0,
        ST_PRESENT = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LINK,
        S_CHECK,
        S_FINISH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // input item taken this cycle
        logic capture;    // child link word is on the link RAM output
        logic check;      // validate link, follow or allocate
        logic finish;     // produce the result item, return to root
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic key_failed;
        logic last;
        logic out_free;
    } t_stat;

endpackage

// ----- hw/rtl/digit_trie_seen_set.sv -----
// ----------------------------------------------------------------------------
// digit_trie_seen_set
// Set of decimal keys kept as a digit trie in a fixed node pool.
// ----------------------------------------------------------------------------
// Steps: each digit is accepted, its child link is read from the link RAM, then
//   the parent/mark check runs; a final digit adds a finish step. Once the key has
//   run out of nodes, each digit is only accepted and a final one then finishes.
//   A final digit's result enters the output register in the finish step, later
//   while the previous result still waits there; the next item is taken in the cycle after.
// Reset: synchronous; links are checked against a parent back-pointer, no RAM clearing.
module digit_trie_seen_set
    import dtss_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [DIGIT_W-1:0]  i_digit,
    input  logic                i_last_digit,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status
);

    t_cmd  cmd;
    t_stat stat;

    dtss_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_last_digit (i_last_digit),
        .i_stat       (stat),
        .o_in_ready   (o_in_ready),
        .o_cmd        (cmd)
    );

    dtss_datapath #(.MAX_NODES(MAX_NODES)) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_digit      (i_digit),
        .i_last_digit (i_last_digit),
        .i_out_ready  (i_out_ready),
        .o_stat       (stat),
        .o_out_valid  (o_out_valid),
        .o_status     (o_status)
    );

endmodule

// ----- hw/rtl/dtss_ram.sv -----
// ----------------------------------------------------------------------------
// dtss_ram
// Generic simple dual-port RAM, one write and one registered read port.
// Contents start at zero on power-up.
// ----------------------------------------------------------------------------
module dtss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // defined power-up contents
    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            r_mem[i] = '0;
        end
    end

    always @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/dtss_ctrl.sv -----
// ----------------------------------------------------------------------------
// dtss_ctrl
// Sequencer for one digit: link read, check/allocate, optional result.
// ----------------------------------------------------------------------------
module dtss_ctrl
    import dtss_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_last_digit,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    // a key that ran out of nodes only waits for its last digit
                    if (i_stat.key_failed) begin
                        n_state = i_last_digit ? S_FINISH : S_IDLE;
                    end else begin
                        n_state = S_LINK;
                    end
                end
            end
            S_LINK:   n_state = S_CHECK;
            S_CHECK:  n_state = i_stat.last ? S_FINISH : S_IDLE;
            S_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.accept   = i_in_valid;
            end
            S_LINK:   o_cmd.capture = 1'b1;
            S_CHECK:  o_cmd.check   = 1'b1;
            S_FINISH: o_cmd.finish  = i_stat.out_free;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/dtss_datapath.sv -----
// ----------------------------------------------------------------------------
// dtss_datapath
// Walk registers, node pool counter and the three trie RAMs.
// A child link counts only if it points to an allocated node whose stored
// parent slot is this one, so no RAM needs clearing at reset.
// ----------------------------------------------------------------------------
module dtss_datapath
    import dtss_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [DIGIT_W-1:0]  i_digit,
    input  logic                i_last_digit,
    input  logic                i_out_ready,
    output t_stat               o_stat,
    output logic                o_out_valid,
    output logic [STATUS_W-1:0] o_status
);

    localparam int NW    = $clog2(MAX_NODES);
    localparam int UW    = $clog2(MAX_NODES + 1);
    localparam int SLOTS = MAX_NODES * FANOUT;
    localparam int SW    = $clog2(SLOTS);

    logic [NW-1:0]  r_cur;
    logic [UW-1:0]  r_used;
    logic           r_failed;
    logic [SW-1:0]  r_slot;
    logic           r_last;
    logic [NW-1:0]  r_child;
    logic           r_mark;
    logic           r_out_valid;
    t_status        r_status;

    logic [DIGIT_W-1:0] digit_sat;
    logic [SW-1:0]      slot_c;
    logic [NW-1:0]      link_q;
    logic [SW-1:0]      parent_q;
    logic               mark_q;
    logic               child_ok;
    logic               pool_full;
    logic               alloc;
    logic               mark_we;
    logic [NW-1:0]      mark_waddr;

    assign digit_sat = (i_digit >= DIGIT_W'(FANOUT)) ? DIGIT_MAX : i_digit;
    assign slot_c    = SW'(r_cur) * SW'(FANOUT) + SW'(digit_sat);

    assign pool_full = (r_used == UW'(MAX_NODES));
    assign child_ok  = (r_child != '0) && (UW'(r_child) < r_used) && (parent_q == r_slot);
    assign alloc     = i_cmd.check && !child_ok && !pool_full;

    // cleared on allocation, set when a key ends here for the first time
    assign mark_we    = alloc || (i_cmd.finish && !r_failed && !r_mark);
    assign mark_waddr = i_cmd.finish ? r_cur : NW'(r_used);

    dtss_ram #(.WIDTH(NW), .DEPTH(SLOTS)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (alloc),
        .i_waddr (r_slot),
        .i_wdata (NW'(r_used)),
        .i_raddr (slot_c),
        .o_rdata (link_q)
    );

    dtss_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (alloc),
        .i_waddr (NW'(r_used)),
        .i_wdata (r_slot),
        .i_raddr (link_q),
        .o_rdata (parent_q)
    );

    dtss_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (mark_waddr),
        .i_wdata (i_cmd.finish),
        .i_raddr (link_q),
        .o_rdata (mark_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_used      <= UW'(1);
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.check) begin
                if (child_ok) begin
                    r_cur <= r_child;
                end else if (pool_full) begin
                    r_failed <= 1'b1;
                end else begin
                    r_cur  <= NW'(r_used);
                    r_used <= UW'(r_used + 1'b1);
                end
            end
            if (i_cmd.finish) begin
                r_cur       <= '0;
                r_failed    <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_slot <= slot_c;
            r_last <= i_last_digit;
        end
        if (i_cmd.capture) begin
            r_child <= link_q;
        end
        if (i_cmd.check) begin
            r_mark <= child_ok ? mark_q : 1'b0;
        end
        if (i_cmd.finish) begin
            if (r_failed) begin
                r_status <= ST_FULL;
            end else if (r_mark) begin
                r_status <= ST_PRESENT;
            end else begin
                r_status <= ST_NEW;
            end
        end
    end

    assign o_stat.key_failed = r_failed;
    assign o_stat.last       = r_last;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;

endmodule

// ----- hw/rtl/dtss_checker.sv -----
// ----------------------------------------------------------------------------
// dtss_checker
// Port-level checks of the trie seen-set, bound to the top level.
// ----------------------------------------------------------------------------
module dtss_checker
    import dtss_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic [DIGIT_W-1:0]  i_digit,
    input logic                i_last_digit,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic [STATUS_W-1:0] o_status
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status))
        else $error("result item changed while stalled");

    // the block is busy right after taking the last digit of a key
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_last_digit |=> !o_in_ready)
        else $error("input ready right after a final digit");

    // a result only shows up after a busy cycle
    a_rose_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result item without a busy cycle before it");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind digit_trie_seen_set dtss_checker u_dtss_checker (.*);
